### rtl/absrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// absrc_pkg: shared types and constants for the source-over alpha blender
// Pixel layout, blend mode codes, register indexes and the fixed-point
// constants of the exact integer source-over arithmetic.
// ----------------------------------------------------------------------------
package absrc_pkg;

    // One 8-bit RGBA pixel, red in the lowest byte.
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_rgba;

    // How a pixel is treated, decided from the channel count register.
    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_COPY,
        MODE_BLEND
    } t_mode;

    // Colour data that rides along with every pipeline stage.
    typedef struct packed {
        t_mode mode;
        t_rgba dst;
        t_rgba src;
    } t_pix;

    // Configuration register indexes.
    localparam logic CFG_OPACITY  = 1'b0;
    localparam logic CFG_CHANNELS = 1'b1;

    // Register reset values and the channel counts that select copy and blend.
    localparam logic [7:0] OPACITY_RESET  = 8'd255;
    localparam logic [2:0] CHANNELS_RESET = 3'd4;
    localparam logic [2:0] CHANNELS_COPY  = 3'd3;
    localparam logic [2:0] CHANNELS_BLEND = 3'd4;

    // 255 squared: full effective alpha.
    localparam logic [15:0] FULL_SQ = 16'd65025;

    // Division: three colour lanes, one quotient bit a stage. The last
    // quotient lane carries the output alpha alongside them.
    localparam int LANES      = 4;
    localparam int LANE_ALPHA = 3;
    localparam int DIV_STEPS  = 8;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 24;

    // floor(den / 65025) is (den * ALPHA_RECIP) >> ALPHA_SHIFT, exact for any
    // den below 2^24.
    localparam int          ALPHA_SHIFT = 40;
    localparam logic [24:0] ALPHA_RECIP = 25'd16909061;
    localparam int          PROD_W      = DEN_W + 25;

    // State of the division lanes in one stage.
    typedef struct packed {
        t_pix                               pix;
        logic [DEN_W-1:0]                   den;
        logic [LANE_ALPHA-1:0][NUM_W-1:0]   rem;
        logic [LANES-1:0][DIV_STEPS-1:0]    quo;
    } t_div;

endpackage
`default_nettype wire

### rtl/alpha_blend_source_over_top.sv
`default_nettype none
// An accepted input beat passes the three multiply stages and then the eight divider stages.
// Throughput: one pixel per cycle while the output is not stalled; the eleven stage registers each hold a beat,
// and the restoring divider takes one quotient bit in each of its eight stages.
// Back-pressure stalls only the stages that are full, so bubbles are squeezed out.
// Reset clears all stage valid bits and sets opacity to 255 and channel count to 4.
// ----------------------------------------------------------------------------
// alpha_blend_source_over_top: pipelined Porter-Duff source-over blender
// Effective alpha, numerators and the denominator are formed in three
// multiply stages; an eight-stage restoring divider yields the exact colour
// floors, and a reciprocal multiply gives the output alpha.
// ----------------------------------------------------------------------------
module alpha_blend_source_over_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  wire logic [63:0] s_axis_tdata,
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]      m_axis_tdata
);
    import absrc_pkg::*;

    localparam int NST = 3 + DIV_STEPS;

    // Configuration registers.
    logic [7:0] r_opacity;
    logic [2:0] r_channels;

    // Stage valid bits and load enables.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    // Stage 1: effective source alpha.
    t_pix        r_s1_pix;
    logic [15:0] r_s1_s;

    // Stage 2: partial products.
    t_pix        r_s2_pix;
    logic [15:0] r_s2_s;
    logic [15:0] r_s2_t;
    logic [7:0]  r_s2_da;
    logic [LANE_ALPHA-1:0][23:0] r_s2_ps;
    logic [LANE_ALPHA-1:0][15:0] r_s2_pd;

    // Stage 3: numerators and denominator.
    t_pix                          r_s3_pix;
    logic [DEN_W-1:0]              r_s3_den;
    logic [LANE_ALPHA-1:0][NUM_W-1:0] r_s3_num;

    // Divider stages.
    t_div r_dv    [DIV_STEPS];
    t_div n_dv    [DIV_STEPS];
    t_div w_dv_in [DIV_STEPS];

    logic [PROD_W-1:0] w_alpha_prod;

    t_mode w_mode;
    t_div  w_last;
    t_rgba w_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity  <= OPACITY_RESET;
            r_channels <= CHANNELS_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_OPACITY:  r_opacity  <= i_cfg_wdata;
                CFG_CHANNELS: r_channels <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NST-1];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Mode follows the channel count at the time the beat enters.
    always_comb begin
        if (r_channels >= CHANNELS_BLEND) begin
            w_mode = MODE_BLEND;
        end else if (r_channels == CHANNELS_COPY) begin
            w_mode = MODE_COPY;
        end else begin
            w_mode = MODE_PASS;
        end
    end

    // Stage 1: S = src_alpha * opacity.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_pix.mode <= w_mode;
            r_s1_pix.src  <= s_axis_tdata[31:0];
            r_s1_pix.dst  <= s_axis_tdata[63:32];
            r_s1_s        <= 16'(s_axis_tdata[31:24]) * 16'(r_opacity);
        end
    end

    // Stage 2: complement of S and per-channel products.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_pix <= r_s1_pix;
            r_s2_s   <= r_s1_s;
            r_s2_t   <= FULL_SQ - r_s1_s;
            r_s2_da  <= r_s1_pix.dst.a;
            r_s2_ps[0] <= 24'(r_s1_pix.src.r) * 24'(r_s1_s);
            r_s2_ps[1] <= 24'(r_s1_pix.src.g) * 24'(r_s1_s);
            r_s2_ps[2] <= 24'(r_s1_pix.src.b) * 24'(r_s1_s);
            r_s2_pd[0] <= 16'(r_s1_pix.dst.r) * 16'(r_s1_pix.dst.a);
            r_s2_pd[1] <= 16'(r_s1_pix.dst.g) * 16'(r_s1_pix.dst.a);
            r_s2_pd[2] <= 16'(r_s1_pix.dst.b) * 16'(r_s1_pix.dst.a);
        end
    end

    // Stage 3: den = 255*S + da*T and num = 255*cs*S + cd*da*T.
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_pix <= r_s2_pix;
            r_s3_den <= ({r_s2_s, 8'd0} - {8'd0, r_s2_s})
                        + (24'(r_s2_da) * 24'(r_s2_t));
            for (int l = 0; l < LANE_ALPHA; l++) begin
                r_s3_num[l] <= ({r_s2_ps[l], 8'd0} - {8'd0, r_s2_ps[l]})
                               + (32'(r_s2_pd[l]) * 32'(r_s2_t));
            end
        end
    end

    // Divider input: colour lanes divide by den; the output alpha, den over
    // 65025, comes from one reciprocal multiply and rides in the alpha lane.
    always_comb begin
        w_alpha_prod = PROD_W'(r_s3_den) * PROD_W'(ALPHA_RECIP);
        w_dv_in[0].pix = r_s3_pix;
        w_dv_in[0].den = r_s3_den;
        w_dv_in[0].quo = '0;
        w_dv_in[0].quo[LANE_ALPHA] = w_alpha_prod[ALPHA_SHIFT +: DIV_STEPS];
        for (int l = 0; l < LANE_ALPHA; l++) begin
            w_dv_in[0].rem[l] = r_s3_num[l];
        end
        for (int j = 1; j < DIV_STEPS; j++) begin
            w_dv_in[j] = r_dv[j-1];
        end
    end

    // One restoring division step per stage, most significant quotient bit first.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int K = DIV_STEPS - 1 - j;

        logic [NUM_W-1:0] w_dsh;

        assign w_dsh = NUM_W'(w_dv_in[j].den) << K;

        always_comb begin
            n_dv[j] = w_dv_in[j];
            for (int l = 0; l < LANE_ALPHA; l++) begin
                if (w_dv_in[j].rem[l] >= w_dsh) begin
                    n_dv[j].rem[l]    = w_dv_in[j].rem[l] - w_dsh;
                    n_dv[j].quo[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[3+j]) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    // Result selection by mode; a zero denominator leaves the pixel unchanged.
    assign w_last = r_dv[DIV_STEPS-1];

    always_comb begin
        w_out = w_last.pix.dst;
        unique case (w_last.pix.mode)
            MODE_BLEND: begin
                if (w_last.den != '0) begin
                    w_out.r = w_last.quo[0];
                    w_out.g = w_last.quo[1];
                    w_out.b = w_last.quo[2];
                    w_out.a = w_last.quo[LANE_ALPHA];
                end
            end
            MODE_COPY: begin
                w_out.r = w_last.pix.src.r;
                w_out.g = w_last.pix.src.g;
                w_out.b = w_last.pix.src.b;
            end
            MODE_PASS: ;
            default: ;
        endcase
    end

    assign m_axis_tdata = w_out;

    // The input side stalls only when every stage holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled while a stage was empty");

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted beat lost at the first stage");

    // After the last step every colour remainder is below the divisor.
    a_col_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_last.pix.mode == MODE_BLEND && w_last.den != '0)
        |-> (w_last.rem[0] < NUM_W'(w_last.den)) && (w_last.rem[1] < NUM_W'(w_last.den))
            && (w_last.rem[2] < NUM_W'(w_last.den)))
        else $error("colour quotient out of range");

    // Blending never lowers the destination alpha.
    a_alpha_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_last.pix.mode == MODE_BLEND)
        |-> (w_last.quo[LANE_ALPHA] >= w_last.pix.dst.a))
        else $error("blended alpha below destination alpha");

endmodule
`default_nettype wire
